>>> rtl/hwc_pkg.sv
// hwc_pkg: shared types and constants for the html whitespace collapser
// no dependencies; used by html_whitespace_collapser

package hwc_pkg;

  // command codes of the input word
  typedef enum logic [1:0] {
    CMD_DOC_START   = 2'd0,
    CMD_ELEM_START  = 2'd1,
    CMD_ELEM_END    = 2'd2,
    CMD_TEXT        = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_CODE_A = 2'd0,
    REG_CODE_B = 2'd1,
    REG_CODE_C = 2'd2,
    REG_CODE_D = 2'd3
  } cfg_reg_t;

  localparam logic [7:0] CODE_A_RESET = 8'd1;
  localparam logic [7:0] CODE_B_RESET = 8'd2;
  localparam logic [7:0] CODE_C_RESET = 8'd3;
  localparam logic [7:0] CODE_D_RESET = 8'd4;

  // whitespace characters
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_LF    = 8'h0a;

  localparam int DEFAULT_STACK_DEPTH = 16;
  localparam int DEFAULT_TAG_BITS    = 8;

  // result buffer
  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = 2;
  localparam int RES_CW    = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovf;
  } res_word_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_FF);
  endfunction

endpackage

>>> rtl/hwc_ram.sv
// hwc_ram: generic single-write, single-read ram with registered read data
// no dependencies

module hwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/html_whitespace_collapser.sv
// html_whitespace_collapser: top level of the html whitespace collapser
// depends on hwc_pkg and hwc_ram

// Takes html parse events (document start, element start/end with a keyword
// code, text bytes with a last-of-node flag) and emits text bytes with
// whitespace runs collapsed: outside a sensitive element a run of space, tab,
// cr, ff or lf within one text node becomes a single lf if it held an lf,
// else its first character, held back until the next byte let through or the
// node end. Inside a sensitive element (one of four programmable keyword
// codes, tracked on a stack of STACK_DEPTH entries in a small ram) text
// passes through unchanged. A push onto a full stack is dropped and sets the
// sticky stack_overflow flag, cleared only by reset. An accepted word is held
// in the input register, is processed from there and lands in a four-word
// result buffer, from whose head the result words are offered. One input
// word is taken every cycle as long as the result buffer holds at most two
// words; the output side drains one word a cycle while result_stall is low,
// so a stream whose words each yield at most one result runs at one word per
// cycle, and the rate is set by that output port. The top of stack is read
// from the ram each cycle, addressed by the depth that the word being
// processed leaves behind, with a one-cycle bypass after a push.
// Configuration writes are always ready and should be issued only while the
// block is idle.

module html_whitespace_collapser #(
  parameter int STACK_DEPTH = hwc_pkg::DEFAULT_STACK_DEPTH,
  parameter int TAG_BITS    = hwc_pkg::DEFAULT_TAG_BITS
) (
  input  logic                clk,
  input  logic                rst,
  // input word channel
  input  logic                item_valid,
  output logic                item_stall,
  input  hwc_pkg::cmd_t       cmd,
  input  logic [7:0]          tag_code,
  input  logic [7:0]          text_byte,
  input  logic                node_end,
  // result word channel
  output logic                result_valid,
  input  logic                result_stall,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                stack_overflow,
  // configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  hwc_pkg::cfg_reg_t   cfg_index,
  input  logic [7:0]          cfg_data
);

  import hwc_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int TW = (TAG_BITS > 8) ? TAG_BITS : 8;

  // configuration registers
  logic [7:0] code_a, code_b, code_c, code_d;

  // input register
  logic                s1_valid;
  cmd_t                s1_cmd;
  logic [TAG_BITS-1:0] s1_tag;
  logic [7:0]          s1_byte;
  logic                s1_last;

  // collapse state
  logic [DW-1:0] depth, depth_next;
  logic          pend_valid, pend_valid_next;
  logic [7:0]    pend_char, pend_char_next;
  logic          ovf, ovf_next;

  // top of stack: ram read data, or the tag pushed on the previous cycle
  logic                byp_valid;
  logic [TAG_BITS-1:0] byp_tag;
  logic [TAG_BITS-1:0] ram_rd_data;
  logic [TAG_BITS-1:0] top_tag;
  logic [AW-1:0]       ram_rd_addr;
  logic                push;

  // result buffer
  res_word_t       res_buf [RES_DEPTH];
  logic [RES_AW-1:0] res_head;
  logic [RES_CW-1:0] res_count;
  logic              res_room;
  logic              res_pop;
  logic [1:0]        n_res;
  res_word_t         res0, res1;
  logic [RES_AW-1:0] tail0, tail1;

  logic go;
  logic accept;
  logic sensitive;
  logic [TW-1:0] tag_wide;
  logic [TW-1:0] wa, wb, wc, wd;

  // keyword codes compared at TAG_BITS bits
  assign tag_wide = TW'(tag_code);
  assign wa = TW'(code_a);
  assign wb = TW'(code_b);
  assign wc = TW'(code_c);
  assign wd = TW'(code_d);

  assign sensitive = (s1_tag == wa[TAG_BITS-1:0]) || (s1_tag == wb[TAG_BITS-1:0]) ||
                     (s1_tag == wc[TAG_BITS-1:0]) || (s1_tag == wd[TAG_BITS-1:0]);

  // handshakes
  assign res_room     = res_count <= RES_CW'(RES_DEPTH - 2);
  assign go           = s1_valid && res_room;
  assign item_stall   = s1_valid && !res_room;
  assign accept       = item_valid && !item_stall;
  assign cfg_ready    = 1'b1;
  assign result_valid = res_count != '0;
  assign res_pop      = result_valid && !result_stall;

  assign top_tag = byp_valid ? byp_tag : ram_rd_data;

  // one word of processing
  always_comb begin
    depth_next      = depth;
    pend_valid_next = pend_valid;
    pend_char_next  = pend_char;
    ovf_next        = ovf;
    push            = 1'b0;
    n_res           = 2'd0;
    res0            = '{data: pend_char, last: 1'b0, ovf: ovf};
    res1            = '{data: s1_byte, last: s1_last, ovf: ovf};
    if (go) begin
      unique case (s1_cmd)
        CMD_DOC_START: begin
          depth_next      = '0;
          pend_valid_next = 1'b0;
          pend_char_next  = '0;
        end
        CMD_ELEM_START: begin
          if (sensitive) begin
            if (depth < DW'(STACK_DEPTH)) begin
              push       = 1'b1;
              depth_next = depth + 1'b1;
            end else begin
              ovf_next = 1'b1;
            end
          end
        end
        CMD_ELEM_END: begin
          if (depth != '0 && top_tag == s1_tag) begin
            depth_next = depth - 1'b1;
          end
        end
        CMD_TEXT: begin
          if (depth != '0 || !(s1_byte == CH_LF || is_blank(s1_byte))) begin
            // pass-through byte, flushing any held whitespace first
            if (pend_valid) begin
              n_res = 2'd2;
            end else begin
              n_res = 2'd1;
              res0  = res1;
            end
            pend_valid_next = 1'b0;
            pend_char_next  = '0;
          end else begin
            // whitespace outside a sensitive element
            if (s1_byte == CH_LF || !pend_valid) begin
              pend_char_next = s1_byte;
            end
            pend_valid_next = 1'b1;
            if (s1_last) begin
              n_res           = 2'd1;
              res0            = '{data: pend_char_next, last: 1'b1, ovf: ovf};
              pend_valid_next = 1'b0;
              pend_char_next  = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // read the entry that will be on top after this cycle
  assign ram_rd_addr = (depth_next == '0) ? '0 : AW'(depth_next - 1'b1);

  hwc_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_stack (
    .clk     (clk),
    .wr_en   (push),
    .wr_addr (depth[AW-1:0]),
    .wr_data (s1_tag),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign tail0 = res_head + res_count[RES_AW-1:0];
  assign tail1 = tail0 + 1'b1;

  // result word shown from the buffer head
  assign out_byte       = res_buf[res_head].data;
  assign out_last       = res_buf[res_head].last;
  assign stack_overflow = res_buf[res_head].ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_a     <= CODE_A_RESET;
      code_b     <= CODE_B_RESET;
      code_c     <= CODE_C_RESET;
      code_d     <= CODE_D_RESET;
      s1_valid   <= 1'b0;
      depth      <= '0;
      pend_valid <= 1'b0;
      pend_char  <= '0;
      ovf        <= 1'b0;
      byp_valid  <= 1'b0;
      res_head   <= '0;
      res_count  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CODE_A: code_a <= cfg_data;
          REG_CODE_B: code_b <= cfg_data;
          REG_CODE_C: code_c <= cfg_data;
          REG_CODE_D: code_d <= cfg_data;
          default: ;
        endcase
      end
      s1_valid   <= accept || (s1_valid && !go);
      depth      <= depth_next;
      pend_valid <= pend_valid_next;
      pend_char  <= pend_char_next;
      ovf        <= ovf_next;
      byp_valid  <= push;
      if (res_pop) begin
        res_head <= res_head + 1'b1;
      end
      res_count <= res_count + RES_CW'(n_res) - RES_CW'(res_pop);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd  <= cmd;
      s1_tag  <= tag_wide[TAG_BITS-1:0];
      s1_byte <= text_byte;
      s1_last <= node_end;
    end
    if (push) begin
      byp_tag <= s1_tag;
    end
    if (n_res != 2'd0) begin
      res_buf[tail0] <= res0;
    end
    if (n_res == 2'd2) begin
      res_buf[tail1] <= res1;
    end
  end

`ifndef SYNTHESIS
  a_res_count: assert property (@(posedge clk) disable iff (rst)
    res_count <= RES_CW'(RES_DEPTH))
    else $error("result buffer overrun");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    ovf |=> ovf)
    else $error("overflow flag cleared without reset");

  a_pend_ws: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (pend_char == CH_LF || is_blank(pend_char)))
    else $error("held character is not whitespace");

  a_no_res_on_tag: assert property (@(posedge clk) disable iff (rst)
    (go && s1_cmd != CMD_TEXT) |-> n_res == 2'd0)
    else $error("element or document event produced output");
`endif

endmodule

>>> tb/html_whitespace_collapser_checker.sv
// html_whitespace_collapser_checker: watches the word, result and register channels,
// predicts the collapsed text stream and compares it field by field
// depends on hwc_pkg

module html_whitespace_collapser_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_stall,
  input  hwc_pkg::cmd_t     cmd,
  input  logic [7:0]        tag_code,
  input  logic [7:0]        text_byte,
  input  logic              node_end,
  input  logic              result_valid,
  input  logic              result_stall,
  input  logic [7:0]        out_byte,
  input  logic              out_last,
  input  logic              stack_overflow,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  hwc_pkg::cfg_reg_t cfg_index,
  input  logic [7:0]        cfg_data,
  output int                fail_count,
  output int                words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import hwc_pkg::*;

  localparam int OPEN_MAX = DEFAULT_STACK_DEPTH;

  logic [7:0] codes [4];
  logic [7:0] open_tags [OPEN_MAX];
  logic [4:0] open_depth;
  logic       held_valid;
  logic [7:0] held_char;
  logic       ovf_sticky;
  res_word_t  text_due_q [$];
  int         fails = 0;

  function automatic logic gap_char(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_FF);
  endfunction

  function automatic logic guarded_tag(input logic [7:0] t);
    return (t == codes[0]) || (t == codes[1]) || (t == codes[2]) || (t == codes[3]);
  endfunction

  task automatic flag_mismatch(input string what);
    fails++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic emit_text(input logic [7:0] b, input logic l);
    res_word_t w;
    w.data = b;
    w.last = l;
    w.ovf  = ovf_sticky;
    text_due_q.insert(text_due_q.size(), w);
  endtask

  // flush the held blank, if any, then the byte itself
  task automatic flush_then(input logic [7:0] b, input logic e);
    if (held_valid) emit_text(held_char, 1'b0);
    held_valid = 1'b0;
    held_char  = 8'h00;
    emit_text(b, e);
  endtask

  task automatic collapse_word(input cmd_t c, input logic [7:0] t, input logic [7:0] b,
                               input logic e);
    case (c)
      CMD_DOC_START: begin
        open_depth = '0;
        held_valid = 1'b0;
        held_char  = 8'h00;
      end
      CMD_ELEM_START: begin
        if (guarded_tag(t)) begin
          if (open_depth < OPEN_MAX) begin
            open_tags[open_depth] = t;
            open_depth++;
          end else begin
            ovf_sticky = 1'b1;
          end
        end
      end
      CMD_ELEM_END: begin
        if (open_depth != 0 && open_tags[open_depth - 1] == t) open_depth--;
      end
      default: begin
        if (open_depth != 0) begin
          flush_then(b, e);
        end else if (b == CH_LF || gap_char(b)) begin
          // a newline anywhere in the run wins, otherwise keep the first blank
          if (b == CH_LF) begin
            held_valid = 1'b1;
            held_char  = CH_LF;
          end else if (!held_valid) begin
            held_valid = 1'b1;
            held_char  = b;
          end
          if (e) begin
            emit_text(held_char, 1'b1);
            held_valid = 1'b0;
            held_char  = 8'h00;
          end
        end else begin
          flush_then(b, e);
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    res_word_t want;
    if (rst) begin
      codes[0]   = CODE_A_RESET;
      codes[1]   = CODE_B_RESET;
      codes[2]   = CODE_C_RESET;
      codes[3]   = CODE_D_RESET;
      open_depth = '0;
      held_valid = 1'b0;
      held_char  = 8'h00;
      ovf_sticky = 1'b0;
      text_due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) codes[cfg_index] = cfg_data;
      if (item_valid && !item_stall) collapse_word(cmd, tag_code, text_byte, node_end);
      if (result_valid && !result_stall) begin
        if (text_due_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected word byte %02h last %b ovf %b",
                                  out_byte, out_last, stack_overflow));
        end else begin
          want = text_due_q.pop_front();
          if (out_byte !== want.data)
            flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte, want.data));
          if (out_last !== want.last)
            flag_mismatch($sformatf("out_last %b, want %b (byte %02h)",
                                    out_last, want.last, want.data));
          if (stack_overflow !== want.ovf)
            flag_mismatch($sformatf("stack_overflow %b, want %b",
                                    stack_overflow, want.ovf));
        end
      end
    end
    fail_count <= fails;
    words_due  <= text_due_q.size();
  end

endmodule

>>> tb/html_whitespace_collapser_test.sv
// html_whitespace_collapser_test: stimulus and verdict for html_whitespace_collapser
// depends on hwc_pkg, html_whitespace_collapser and html_whitespace_collapser_checker

module html_whitespace_collapser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import hwc_pkg::*;

  localparam int HOLD_CYCLES = 40;      // long receiver hold-off
  localparam int SETTLE      = 8;       // block latency slack for words with no result
  localparam int CYCLE_LIMIT = 300000;

  logic       clk;
  logic       rst;
  logic       item_valid;
  logic       item_stall;
  cmd_t       cmd;
  logic [7:0] tag_code;
  logic [7:0] text_byte;
  logic       node_end;
  logic       result_valid;
  logic       result_stall;
  logic [7:0] out_byte;
  logic       out_last;
  logic       stack_overflow;
  logic       cfg_valid;
  logic       cfg_ready;
  cfg_reg_t   cfg_index;
  logic [7:0] cfg_data;
  int         fail_count;
  int         words_due;

  // stimulus-side bookkeeping only, used to shape sequences
  logic [7:0] cur_codes [4];
  logic [7:0] open_q [$];
  int         sent = 0;
  int         cycles = 0;
  logic       quiet = 1'b0;      // no idling on either side
  logic       hold_req = 1'b0;   // ask the receiver for a long hold-off

  html_whitespace_collapser dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .cmd            (cmd),
    .tag_code       (tag_code),
    .text_byte      (text_byte),
    .node_end       (node_end),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .stack_overflow (stack_overflow),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  html_whitespace_collapser_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .cmd            (cmd),
    .tag_code       (tag_code),
    .text_byte      (text_byte),
    .node_end       (node_end),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .stack_overflow (stack_overflow),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .words_due      (words_due)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stall bursts, plus the long hold-off on request
  initial begin
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // offer one word and wait for it to be taken; valid stays high afterwards
  // so back-to-back words never drop it, apart from the random idle gaps taken while not quiet
  task automatic put_word(input cmd_t c, input logic [7:0] t, input logic [7:0] b,
                          input logic e);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd        <= c;
    tag_code   <= t;
    text_byte  <= b;
    node_end   <= e;
    do @(posedge clk); while (item_stall);
    sent++;
  endtask

  // unused fields carry random values so that they are shown to be ignored
  task automatic send_text(input logic [7:0] b, input logic e);
    put_word(CMD_TEXT, 8'($urandom), b, e);
  endtask

  task automatic send_open(input logic [7:0] t);
    put_word(CMD_ELEM_START, t, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_close(input logic [7:0] t);
    put_word(CMD_ELEM_END, t, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_doc();
    put_word(CMD_DOC_START, 8'($urandom), 8'($urandom), 1'($urandom));
  endtask

  // sender goes quiet until every expected word is back, plus latency slack
  task automatic pause_until_drained();
    item_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all four sensitive codes, written while the block is idle
  task automatic set_codes(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                           input logic [7:0] d);
    write_reg(REG_CODE_A, a);
    write_reg(REG_CODE_B, b);
    write_reg(REG_CODE_C, c);
    write_reg(REG_CODE_D, d);
    cfg_valid <= 1'b0;
    cur_codes[0] = a;
    cur_codes[1] = b;
    cur_codes[2] = c;
    cur_codes[3] = d;
  endtask

  function automatic logic [7:0] pick_code();
    return cur_codes[$urandom_range(0, 3)];
  endfunction

  function automatic logic is_code(input logic [7:0] t);
    return (t == cur_codes[0]) || (t == cur_codes[1]) || (t == cur_codes[2]) ||
           (t == cur_codes[3]);
  endfunction

  // text bytes lean heavily on whitespace so runs form often
  function automatic logic [7:0] text_pick();
    case ($urandom_range(0, 9))
      0, 1:    return CH_SPACE;
      2:       return CH_TAB;
      3:       return CH_CR;
      4:       return CH_FF;
      5:       return CH_LF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // mostly well-formed documents: text nodes between matched sensitive
  // elements, with stray ends, foreign tags, unfinished nodes and restarts
  task automatic random_traffic(input int count, input logic deep_ok);
    int         stop_at;
    int         pick;
    int         len;
    logic [7:0] t;
    logic       e;
    stop_at = sent + count;
    while (sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        send_doc();
        open_q.delete();
      end else if (pick < 23) begin
        if ($urandom_range(0, 2) != 0) t = pick_code();
        else t = 8'($urandom_range(0, 255));
        send_open(t);
        if (is_code(t)) open_q.insert(open_q.size(), t);
      end else if (pick < 38) begin
        if (open_q.size() != 0 && $urandom_range(0, 3) != 0) begin
          t = open_q[$];
          open_q.delete(open_q.size() - 1);
        end else begin
          t = 8'($urandom_range(0, 255));
        end
        send_close(t);
      end else if (pick < 40 && deep_ok) begin
        // nest past the stack size to hit the dropped push
        repeat ($urandom_range(12, 20)) begin
          t = pick_code();
          send_open(t);
          open_q.insert(open_q.size(), t);
        end
      end else begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          // mostly closed on the last byte, now and then left open or cut short
          if (i == len - 1) e = ($urandom_range(0, 9) != 0);
          else e = ($urandom_range(0, 19) == 0);
          send_text(text_pick(), e);
        end
      end
    end
  endtask

  initial begin
    rst        <= 1'b1;
    item_valid <= 1'b0;
    cmd        <= CMD_DOC_START;
    tag_code   <= 8'h00;
    text_byte  <= 8'h00;
    node_end   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= REG_CODE_A;
    cfg_data   <= 8'h00;
    cur_codes[0] = CODE_A_RESET;
    cur_codes[1] = CODE_B_RESET;
    cur_codes[2] = CODE_C_RESET;
    cur_codes[3] = CODE_D_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed, reset codes
    send_doc();
    send_text("a", 1'b0);
    send_text(CH_SPACE, 1'b0);       // run keeps its first blank
    send_text(CH_TAB, 1'b0);
    send_text("b", 1'b0);
    send_text(CH_CR, 1'b0);          // run with a newline becomes a newline
    send_text(CH_LF, 1'b0);
    send_text(CH_SPACE, 1'b0);
    send_text("c", 1'b0);
    send_text(CH_SPACE, 1'b1);       // node ends on a blank
    send_text(8'h00, 1'b0);
    send_text(8'hff, 1'b1);
    send_text(CH_FF, 1'b0);          // held across an element start
    send_open(CODE_A_RESET);
    send_text(CH_SPACE, 1'b0);       // held blank comes out first, then raw text
    send_text(CH_LF, 1'b1);
    send_close(8'h09);               // not the top, ignored
    send_close(CODE_A_RESET);
    send_close(CODE_A_RESET);        // empty stack, ignored
    send_open(8'hff);                // not sensitive
    send_open(8'h00);
    send_text(CH_SPACE, 1'b0);
    send_doc();                      // drops the held blank
    send_text("d", 1'b1);
    pause_until_drained();

    // reset codes again through the port; the receiver holds off long enough
    // for the block to fill up and stall its input
    set_codes(CODE_A_RESET, CODE_B_RESET, CODE_C_RESET, CODE_D_RESET);
    quiet = 1'b1;
    hold_req = 1'b1;
    send_doc();
    for (int i = 0; i < 30; i++) send_text(8'h41 + 8'(i), i == 29);
    quiet = 1'b0;
    random_traffic(170, 1'b0);
    pause_until_drained();

    set_codes(8'h00, 8'h00, 8'h00, 8'h00);
    random_traffic(180, 1'b0);
    pause_until_drained();

    // overflow becomes possible from here on
    set_codes(8'hff, 8'hff, 8'hff, 8'hff);
    random_traffic(180, 1'b1);
    pause_until_drained();

    set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    random_traffic(180, 1'b1);
    pause_until_drained();

    // last stretch runs with no idling at all
    set_codes(8'h00, 8'hff, 8'h55, 8'haa);
    quiet = 1'b1;
    random_traffic(190, 1'b1);

    item_valid <= 1'b0;
    do @(posedge clk); while (words_due != 0);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
